// File: src/snfcs_pkg.sv
// Shared types, opcodes and the result generator for the SPI NOR flash sequencer.
// No dependencies.
`timescale 1ns / 1ps
package snfcs_pkg;

	localparam logic [3:0] K_READ   = 4'd0;
	localparam logic [3:0] K_WRITE  = 4'd1;
	localparam logic [3:0] K_SERASE = 4'd2;
	localparam logic [3:0] K_CERASE = 4'd3;
	localparam logic [3:0] K_JEDEC  = 4'd4;
	localparam logic [3:0] K_DEVID  = 4'd5;
	localparam logic [3:0] K_PDOWN  = 4'd6;
	localparam logic [3:0] K_WAKE   = 4'd7;
	localparam logic [3:0] K_DATA   = 4'd8;
	localparam logic [3:0] K_REPLY  = 4'd9;

	localparam logic [7:0] CMD_WREN   = 8'h06;
	localparam logic [7:0] CMD_RDSR   = 8'h05;
	localparam logic [7:0] CMD_READ   = 8'h03;
	localparam logic [7:0] CMD_PP     = 8'h02;
	localparam logic [7:0] CMD_SE     = 8'h20;
	localparam logic [7:0] CMD_CE     = 8'hC7;
	localparam logic [7:0] CMD_JEDEC  = 8'h9F;
	localparam logic [7:0] CMD_RES    = 8'hAB;
	localparam logic [7:0] CMD_DP     = 8'hB9;
	localparam logic [7:0] DUMMY      = 8'hFF;

	typedef enum logic [3:0] {
		S_REJ, S_READ, S_EMPTY, S_PAGE, S_SE, S_CE, S_JEDEC, S_DEVID,
		S_BYTECS, S_RDATA, S_FF, S_CSONLY, S_ERASE2, S_ID, S_DATA
	} seq_t;

	typedef struct packed {
		seq_t        seq;
		logic [2:0]  n;
		logic        pre;
		logic        f;
		logic        done;
		logic [23:0] addr;
		logic [7:0]  bval;
		logic [23:0] idv;
	} desc_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        cs_release;
		logic        expect_reply;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic        id_valid;
		logic [23:0] id_value;
		logic        rejected;
	} res_t;

	function automatic res_t tx(input logic [7:0] b, input logic cs, input logic ex);
		res_t r;
		r = '0;
		r.tx_valid = 1'b1;
		r.tx_byte = b;
		r.cs_release = cs;
		r.expect_reply = ex;
		return r;
	endfunction

	function automatic res_t gen(input desc_t d, input logic [2:0] i);
		res_t r;
		logic [2:0] j;
		r = '0;
		j = i - {2'b0, d.pre};
		case (d.seq)
			S_REJ: r.rejected = 1'b1;
			S_READ: begin
				case (i)
					3'd0: r = tx(CMD_READ, 1'b0, 1'b0);
					3'd1: r = tx(d.addr[23:16], 1'b0, 1'b0);
					3'd2: r = tx(d.addr[15:8], 1'b0, 1'b0);
					3'd3: r = tx(d.addr[7:0], d.n == 3'd4, 1'b0);
					default: r = tx(DUMMY, d.f, 1'b1);
				endcase
			end
			S_PAGE: begin
				if (d.pre && i == 3'd0) begin
					r.cs_release = 1'b1;
				end else begin
					case (j)
						3'd0: r = tx(CMD_WREN, 1'b1, 1'b0);
						3'd1: r = tx(CMD_PP, 1'b0, 1'b0);
						3'd2: r = tx(d.addr[23:16], 1'b0, 1'b0);
						3'd3: r = tx(d.addr[15:8], 1'b0, 1'b0);
						default: r = tx(d.addr[7:0], 1'b0, 1'b0);
					endcase
				end
			end
			S_SE: begin
				case (i)
					3'd0: r = tx(CMD_WREN, 1'b1, 1'b0);
					3'd1: r = tx(CMD_RDSR, 1'b0, 1'b0);
					default: r = tx(DUMMY, 1'b0, 1'b1);
				endcase
			end
			S_CE: begin
				case (i)
					3'd0: r = tx(CMD_WREN, 1'b1, 1'b0);
					3'd1: r = tx(CMD_CE, 1'b1, 1'b0);
					3'd2: r = tx(CMD_RDSR, 1'b0, 1'b0);
					default: r = tx(DUMMY, 1'b0, 1'b1);
				endcase
			end
			S_JEDEC: r = (i == 3'd0) ? tx(CMD_JEDEC, 1'b0, 1'b0) : tx(DUMMY, 1'b0, 1'b1);
			S_DEVID: begin
				case (i)
					3'd0: r = tx(CMD_RES, 1'b0, 1'b0);
					3'd4: r = tx(DUMMY, 1'b1, 1'b1);
					default: r = tx(DUMMY, 1'b0, 1'b0);
				endcase
			end
			S_BYTECS: r = tx(d.bval, 1'b1, 1'b0);
			S_RDATA: begin
				if (i == 3'd0) begin
					r.read_valid = 1'b1;
					r.read_byte = d.bval;
				end else begin
					r = tx(DUMMY, d.f, 1'b1);
				end
			end
			S_FF: r = tx(DUMMY, d.f, 1'b1);
			S_CSONLY: r.cs_release = 1'b1;
			S_ERASE2: begin
				case (i)
					3'd0: r.cs_release = 1'b1;
					3'd1: r = tx(CMD_SE, 1'b0, 1'b0);
					3'd2: r = tx(d.addr[23:16], 1'b0, 1'b0);
					3'd3: r = tx(d.addr[15:8], 1'b0, 1'b0);
					3'd4: r = tx(d.addr[7:0], 1'b1, 1'b0);
					3'd5: r = tx(CMD_RDSR, 1'b0, 1'b0);
					default: r = tx(DUMMY, 1'b0, 1'b1);
				endcase
			end
			S_ID: begin
				r.id_valid = 1'b1;
				r.id_value = d.idv;
			end
			S_DATA: begin
				case (i)
					3'd0: r = tx(d.bval, d.f, 1'b0);
					3'd1: r = tx(CMD_RDSR, 1'b0, 1'b0);
					default: r = tx(DUMMY, 1'b0, 1'b1);
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: src/snfcs_if.sv
// Request and result channel interfaces of the flash sequencer.
// No dependencies.
`timescale 1ns / 1ps
interface snfcs_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [23:0] address;
	logic [23:0] length;
	logic [7:0]  data_byte;
	modport source (output valid, kind, address, length, data_byte, input ready);
	modport sink (input valid, kind, address, length, data_byte, output ready);
endinterface

interface snfcs_res_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        cs_release;
	logic        expect_reply;
	logic        read_valid;
	logic [7:0]  read_byte;
	logic        id_valid;
	logic [23:0] id_value;
	logic        op_done;
	logic        rejected;
	logic        last;
	modport source (output valid, tx_valid, tx_byte, cs_release, expect_reply, read_valid,
		read_byte, id_valid, id_value, op_done, rejected, last, input ready);
	modport sink (input valid, tx_valid, tx_byte, cs_release, expect_reply, read_valid,
		read_byte, id_valid, id_value, op_done, rejected, last, output ready);
endinterface

// File: src/snfcs_front.sv
// Front end: accepts requests, holds the protocol state and emits sequence descriptors.
// Depends on snfcs_pkg and snfcs_if.
`timescale 1ns / 1ps
module snfcs_front #(
	parameter int PAGE_BYTES = 256,
	parameter int ADDRESS_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	snfcs_req_if.sink        req,
	output logic             push,
	output snfcs_pkg::desc_t push_desc,
	input  logic             full
);
	import snfcs_pkg::*;

	localparam int PW = $clog2(PAGE_BYTES + 1);

	typedef enum logic [2:0] {
		PH_IDLE, PH_RDATA, PH_WDATA, PH_WPOLL, PH_EPOLL1, PH_EPOLL2, PH_JEDEC, PH_DEVID
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [ADDRESS_BITS-1:0] cursor_q, cursor_d, a;
	logic [23:0]             rem_q, rem_d, rem_m1;
	logic [PW-1:0]           pbl_q, pbl_d, pbl_m1;
	logic [23:0]             acc_q, acc_d;
	logic [2:0]              rc_q, rc_d;
	desc_t                   d;

	function automatic logic [PW-1:0] page_fill(input logic [ADDRESS_BITS-1:0] ad,
		input logic [23:0] r);
		logic [PW-1:0] room;
		room = PW'(PAGE_BYTES) - PW'(ad % PAGE_BYTES);
		return (24'(room) < r) ? room : r[PW-1:0];
	endfunction

	assign req.ready = !full;
	assign push = req.valid && req.ready;
	assign push_desc = d;
	assign a = req.address[ADDRESS_BITS-1:0];
	assign rem_m1 = rem_q - 24'd1;
	assign pbl_m1 = (pbl_q != '0) ? pbl_q - PW'(1) : '0;

	always_comb begin
		phase_d = phase_q;
		cursor_d = cursor_q;
		rem_d = rem_q;
		pbl_d = pbl_q;
		acc_d = acc_q;
		rc_d = rc_q;
		d = '0;
		d.seq = S_REJ;
		d.n = 3'd1;
		d.done = 1'b0;
		d.bval = req.data_byte;
		d.addr = 24'(cursor_q);
		if (req.kind <= K_WAKE) begin
			if (phase_q == PH_IDLE) begin
				case (req.kind)
					K_READ: begin
						d.seq = S_READ;
						d.addr = 24'(a);
						if (req.length == '0) begin
							d.n = 3'd4;
							d.done = 1'b1;
						end else begin
							d.n = 3'd5;
							d.f = req.length == 24'd1;
							rem_d = req.length;
							phase_d = PH_RDATA;
						end
					end
					K_WRITE: begin
						if (req.length == '0) begin
							d.seq = S_EMPTY;
							d.done = 1'b1;
						end else begin
							d.seq = S_PAGE;
							d.n = 3'd5;
							d.addr = 24'(a);
							cursor_d = a;
							rem_d = req.length;
							pbl_d = page_fill(a, req.length);
							phase_d = PH_WDATA;
						end
					end
					K_SERASE: begin
						d.seq = S_SE;
						d.n = 3'd3;
						cursor_d = a;
						phase_d = PH_EPOLL1;
					end
					K_CERASE: begin
						d.seq = S_CE;
						d.n = 3'd4;
						phase_d = PH_EPOLL2;
					end
					K_JEDEC: begin
						d.seq = S_JEDEC;
						d.n = 3'd2;
						acc_d = '0;
						rc_d = '0;
						phase_d = PH_JEDEC;
					end
					K_DEVID: begin
						d.seq = S_DEVID;
						d.n = 3'd5;
						phase_d = PH_DEVID;
					end
					K_PDOWN: begin
						d.seq = S_BYTECS;
						d.bval = CMD_DP;
						d.done = 1'b1;
					end
					default: begin
						d.seq = S_BYTECS;
						d.bval = CMD_RES;
						d.done = 1'b1;
					end
				endcase
			end
		end else if (req.kind == K_DATA) begin
			if (phase_q == PH_WDATA) begin
				pbl_d = pbl_m1;
				rem_d = rem_m1;
				cursor_d = cursor_q + ADDRESS_BITS'(1);
				d.seq = S_DATA;
				if (pbl_m1 == '0 || rem_m1 == '0) begin
					d.n = 3'd3;
					d.f = 1'b1;
					phase_d = PH_WPOLL;
				end
			end
		end else if (req.kind == K_REPLY) begin
			case (phase_q)
				PH_RDATA: begin
					d.seq = S_RDATA;
					rem_d = rem_m1;
					if (rem_m1 == '0) begin
						d.done = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						d.n = 3'd2;
						d.f = rem_m1 == 24'd1;
					end
				end
				PH_WPOLL, PH_EPOLL1, PH_EPOLL2: begin
					if (req.data_byte[0]) begin
						d.seq = S_FF;
					end else if (phase_q == PH_EPOLL1) begin
						d.seq = S_ERASE2;
						d.n = 3'd7;
						phase_d = PH_EPOLL2;
					end else if (phase_q == PH_EPOLL2 || rem_q == '0) begin
						d.seq = S_CSONLY;
						d.done = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						d.seq = S_PAGE;
						d.pre = 1'b1;
						d.n = 3'd6;
						pbl_d = page_fill(cursor_q, rem_q);
						phase_d = PH_WDATA;
					end
				end
				PH_JEDEC: begin
					acc_d = {acc_q[15:0], req.data_byte};
					rc_d = rc_q + 3'd1;
					if (rc_d >= 3'd3) begin
						d.seq = S_ID;
						d.idv = acc_d;
						d.done = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						d.seq = S_FF;
						d.f = rc_d == 3'd2;
					end
				end
				PH_DEVID: begin
					acc_d = {16'd0, req.data_byte};
					d.seq = S_ID;
					d.idv = acc_d;
					d.done = 1'b1;
					phase_d = PH_IDLE;
				end
				default: d.seq = S_REJ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cursor_q <= '0;
			rem_q <= '0;
			pbl_q <= '0;
			acc_q <= '0;
			rc_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			cursor_q <= cursor_d;
			rem_q <= rem_d;
			pbl_q <= pbl_d;
			acc_q <= acc_d;
			rc_q <= rc_d;
		end
	end

endmodule

// File: src/snfcs_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on snfcs_pkg.
`timescale 1ns / 1ps
module snfcs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  snfcs_pkg::desc_t push_desc,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output snfcs_pkg::desc_t head
);
	import snfcs_pkg::*;

	desc_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: src/snfcs_back.sv
// Back end: expands the head descriptor into result transfers, one per cycle while the result channel is ready.
// Depends on snfcs_pkg and snfcs_if.
`timescale 1ns / 1ps
module snfcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  snfcs_pkg::desc_t head,
	output logic             pop,
	snfcs_res_if.source      res
);
	import snfcs_pkg::*;

	logic [2:0] idx_q;
	logic       fin;
	res_t       r;

	assign r = gen(head, idx_q);
	assign fin = idx_q == head.n - 3'd1;
	assign pop = res.valid && res.ready && fin;

	assign res.valid = !empty;
	assign res.tx_valid = r.tx_valid;
	assign res.tx_byte = r.tx_byte;
	assign res.cs_release = r.cs_release;
	assign res.expect_reply = r.expect_reply;
	assign res.read_valid = r.read_valid;
	assign res.read_byte = r.read_byte;
	assign res.id_valid = r.id_valid;
	assign res.id_value = r.id_value;
	assign res.rejected = r.rejected;
	assign res.last = fin;
	assign res.op_done = fin && head.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (res.valid && res.ready) begin
			idx_q <= fin ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

// File: src/spi_nor_flash_command_sequencer_core.sv
// SPI NOR flash command sequencer. Each request, write data byte or shifter reply is
// accepted while the two-entry descriptor queue has room; the back end then emits one
// result transfer per cycle while the result channel is ready, and an item produces at
// most seven results. Write data is split at PAGE_BYTES boundaries.
// Depends on snfcs_pkg, snfcs_if, snfcs_front, snfcs_queue and snfcs_back.
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_core #(
	parameter int PAGE_BYTES = 256,
	parameter int ADDRESS_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	snfcs_req_if.sink   req,
	snfcs_res_if.source res
);
	import snfcs_pkg::*;

	logic  push, full, pop, empty;
	desc_t push_desc, head;

	snfcs_front #(.PAGE_BYTES(PAGE_BYTES), .ADDRESS_BITS(ADDRESS_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.push(push), .push_desc(push_desc), .full(full)
	);

	snfcs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_desc(push_desc), .full(full),
		.pop(pop), .empty(empty), .head(head)
	);

	snfcs_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop), .res(res)
	);

endmodule

// File: src/snfcs_checker.sv
// Port-level checks of the flash sequencer result channel, bound to the top level.
// Depends on spi_nor_flash_command_sequencer_core.
`timescale 1ns / 1ps
module snfcs_checker (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic tx_valid,
	input logic read_valid,
	input logic id_valid,
	input logic op_done,
	input logic rejected,
	input logic last
);
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && op_done |-> last) else $error("done result not last");
	a_rej_alone: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rejected |-> !tx_valid && !op_done && last) else $error("bad reject");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $countones({tx_valid, read_valid, id_valid, rejected}) <= 1)
		else $error("mixed result");
	a_id_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid && id_valid |-> op_done) else $error("id without done");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid) else $error("valid dropped");
endmodule

bind spi_nor_flash_command_sequencer_core snfcs_checker u_checker (
	.clk(clk), .arst_n(arst_n), .valid(res.valid), .ready(res.ready),
	.tx_valid(res.tx_valid), .read_valid(res.read_valid), .id_valid(res.id_valid),
	.op_done(res.op_done), .rejected(res.rejected), .last(res.last)
);
